FILE: src/utcr_pkg.sv
// shared types and constants for the text command recognizer
package utcr_pkg;

  localparam logic [4:0] CMD_START_MAPPING = 5'd0;
  localparam logic [4:0] CMD_STOP_ALL      = 5'd1;
  localparam logic [4:0] CMD_SHOW_MAP      = 5'd2;
  localparam logic [4:0] CMD_CLEAR_MAP     = 5'd3;
  localparam logic [4:0] CMD_DEBUG_ON      = 5'd4;
  localparam logic [4:0] CMD_DEBUG_OFF     = 5'd5;
  localparam logic [4:0] CMD_LIDAR_ON      = 5'd6;
  localparam logic [4:0] CMD_LIDAR_OFF     = 5'd7;
  localparam logic [4:0] CMD_ODOM_ON       = 5'd8;
  localparam logic [4:0] CMD_ODOM_OFF      = 5'd9;
  localparam logic [4:0] CMD_NAV_START     = 5'd10;
  localparam logic [4:0] CMD_NAV_GOAL      = 5'd11;
  localparam logic [4:0] CMD_NAV_RUN       = 5'd12;
  localparam logic [4:0] CMD_NAV_STOP      = 5'd13;
  localparam logic [4:0] CMD_TURN_LEFT_DEG = 5'd14;
  localparam logic [4:0] CMD_TURN_RIGHT_DEG = 5'd15;
  localparam logic [4:0] CMD_FORWARD       = 5'd16;
  localparam logic [4:0] CMD_TURN_LEFT     = 5'd17;
  localparam logic [4:0] CMD_TURN_RIGHT    = 5'd18;
  localparam logic [4:0] CMD_DRIVE_STOP    = 5'd19;
  localparam logic [4:0] CMD_UNKNOWN       = 5'd20;

  // longest keyword that must be compared in full
  localparam int unsigned KEY_MAX = 15;

  // code sits in the lowest bits, as on the result bus
  typedef struct packed {
    logic [15:0] errors;
    logic [15:0] overflows;
    logic        debug;
    logic        mapping;
    logic [4:0]  code;
  } result_t;

endpackage

FILE: src/utcr_matcher.sv
// matches a normalized line against the keyword grammar
module utcr_matcher #(
  parameter int unsigned NORM_W = 6
) (
  input  logic [8*utcr_pkg::KEY_MAX-1:0] head,
  input  logic [NORM_W-1:0]              norm_len,
  input  logic                           all_digits_l,
  input  logic                           all_digits_r,
  input  logic                           all_digits_1,
  output logic [4:0]                     code
);

  logic [7:0] ch [utcr_pkg::KEY_MAX];
  logic [NORM_W:0] len;

  always_comb begin
    for (int i = 0; i < int'(utcr_pkg::KEY_MAX); i++) begin
      ch[i] = head[8*i +: 8];
    end
    len = {1'b0, norm_len};
  end

  function automatic logic is_eq(input logic [8*utcr_pkg::KEY_MAX-1:0] h,
                                 input logic [NORM_W:0] l, input string s);
    logic ok;
    ok = l == (NORM_W+1)'(s.len());
    for (int i = 0; i < s.len(); i++) begin
      if (h[8*i +: 8] != s[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic is_pre(input logic [8*utcr_pkg::KEY_MAX-1:0] h,
                                  input logic [NORM_W:0] l, input string s);
    logic ok;
    ok = l >= (NORM_W+1)'(s.len());
    for (int i = 0; i < s.len(); i++) begin
      if (h[8*i +: 8] != s[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic cell_c(input logic [7:0] c);
    return (c >= "0" && c <= "4") || c == " ";
  endfunction

  logic deg_l, deg_r;

  // digit checks on the tail come from the scan unit
  always_comb begin
    deg_l = (is_pre(head, len, "LEFT") && all_digits_l) ||
            (all_digits_1 && (ch[0] == "L" || ch[0] == "A"));
    deg_r = (is_pre(head, len, "RIGHT") && all_digits_r) ||
            (all_digits_1 && (ch[0] == "R" || ch[0] == "D"));
  end

  // bytes past the line end read as zero, so a lone letter has no cell digit
  always_comb begin
    if (is_eq(head, len, "91")) code = utcr_pkg::CMD_START_MAPPING;
    else if (is_eq(head, len, "1")) code = utcr_pkg::CMD_FORWARD;
    else if (is_eq(head, len, "2")) code = utcr_pkg::CMD_TURN_LEFT;
    else if (is_eq(head, len, "3")) code = utcr_pkg::CMD_TURN_RIGHT;
    else if (is_eq(head, len, "0")) code = utcr_pkg::CMD_DRIVE_STOP;
    else if (is_eq(head, len, "START") || is_eq(head, len, "MAP START") ||
             is_eq(head, len, "START MAP")) code = utcr_pkg::CMD_START_MAPPING;
    else if (is_eq(head, len, "STOP") || is_eq(head, len, "HALT") ||
             is_eq(head, len, "MAP STOP") || is_eq(head, len, "STOP MAP"))
      code = utcr_pkg::CMD_STOP_ALL;
    else if (is_eq(head, len, "SHOW") || is_eq(head, len, "RESULT") ||
             is_eq(head, len, "MAP SHOW") || is_eq(head, len, "SHOW MAP"))
      code = utcr_pkg::CMD_SHOW_MAP;
    else if (is_eq(head, len, "CLEAR") || is_eq(head, len, "CLS") ||
             is_eq(head, len, "MAP CLEAR") || is_eq(head, len, "CLEAR MAP"))
      code = utcr_pkg::CMD_CLEAR_MAP;
    else if (is_eq(head, len, "DEBUG ON") || is_eq(head, len, "DBG ON"))
      code = utcr_pkg::CMD_DEBUG_ON;
    else if (is_eq(head, len, "DEBUG OFF") || is_eq(head, len, "DBG OFF"))
      code = utcr_pkg::CMD_DEBUG_OFF;
    else if (is_eq(head, len, "92") || is_eq(head, len, "LIDAR") ||
             is_eq(head, len, "LIDAR ON") || is_eq(head, len, "LIDAR DEBUG") ||
             is_eq(head, len, "LIDAR DEBUG ON")) code = utcr_pkg::CMD_LIDAR_ON;
    else if (is_eq(head, len, "93") || is_eq(head, len, "LIDAR OFF") ||
             is_eq(head, len, "LIDAR DEBUG OFF")) code = utcr_pkg::CMD_LIDAR_OFF;
    else if (is_eq(head, len, "94") || is_eq(head, len, "ODOM") ||
             is_eq(head, len, "ODOM ON") || is_eq(head, len, "ODOM DEBUG") ||
             is_eq(head, len, "ODOM DEBUG ON")) code = utcr_pkg::CMD_ODOM_ON;
    else if (is_eq(head, len, "95") || is_eq(head, len, "ODOM OFF") ||
             is_eq(head, len, "ODOM DEBUG OFF")) code = utcr_pkg::CMD_ODOM_OFF;
    else if (is_eq(head, len, "98") || is_eq(head, len, "NAV") ||
             is_eq(head, len, "NAV RUN") || is_eq(head, len, "GOAL RUN"))
      code = utcr_pkg::CMD_NAV_RUN;
    else if (is_eq(head, len, "99") || is_eq(head, len, "NAV STOP") ||
             is_eq(head, len, "PATH STOP")) code = utcr_pkg::CMD_NAV_STOP;
    else if ((ch[0] == "S" && cell_c(ch[1])) || is_pre(head, len, "START "))
      code = utcr_pkg::CMD_NAV_START;
    else if (((ch[0] == "E" || ch[0] == "G") && cell_c(ch[1])) ||
             is_pre(head, len, "END ") || is_pre(head, len, "GOAL "))
      code = utcr_pkg::CMD_NAV_GOAL;
    else if (deg_l) code = utcr_pkg::CMD_TURN_LEFT_DEG;
    else if (deg_r) code = utcr_pkg::CMD_TURN_RIGHT_DEG;
    else if (is_eq(head, len, "FWD") || is_eq(head, len, "FORWARD") ||
             is_eq(head, len, "GO")) code = utcr_pkg::CMD_FORWARD;
    else if (is_eq(head, len, "LEFT") || is_eq(head, len, "TURN LEFT"))
      code = utcr_pkg::CMD_TURN_LEFT;
    else if (is_eq(head, len, "RIGHT") || is_eq(head, len, "TURN RIGHT"))
      code = utcr_pkg::CMD_TURN_RIGHT;
    else if (is_eq(head, len, "DRIVE STOP") || is_eq(head, len, "MOTOR STOP") ||
             is_eq(head, len, "BRAKE")) code = utcr_pkg::CMD_DRIVE_STOP;
    else code = utcr_pkg::CMD_UNKNOWN;
  end

endmodule

FILE: src/uart_text_command_recognizer_top.sv
// top level: line store, normalizing scan sequencer and result register
//
// channel  | dir | fields
// s_axis   | in  | tdata[7:0] rx_byte
// m_axis   | out | tdata[4:0] code, [5] mapping, [6] debug, [22:7] overflows,
//          |     | [38:23] errors, [39] zero pad
//
// plain bytes are stored while idle. a line break that closes stored characters runs
// through the read and normalize state, then trim, the tail digit check, match and
// output before the next input is taken. a digit shortcut goes accept, match, output.
// rst is synchronous and clears the state, line length, read flag, mapping and debug
// flags, both counters and m_axis_tvalid. s_axis_tready is low while a line
// is being worked and for as long as a result waits on m_axis_tready.
module uart_text_command_recognizer_top #(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // command_code, mapping flag, debug flag,
                                      // overflow_count, error_count, zero pad
);

  localparam int unsigned AW = $clog2(LINE_MAX);
  localparam int unsigned LW = $clog2(LINE_MAX + 1);
  localparam int unsigned KM = utcr_pkg::KEY_MAX;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_TRIM = 3'd2;
  localparam logic [2:0] ST_TAIL = 3'd3;
  localparam logic [2:0] ST_MATCH = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;

  logic [2:0] state;
  logic [7:0] mem [LINE_MAX];
  logic [7:0] norm [LINE_MAX];
  logic [7:0] rd_data;
  logic [LW-1:0] line_length, src_n, rd_idx, nlen, tp;
  logic prev_space;
  logic first_nine;
  logic mapping, debug;
  logic [15:0] overflows, errors;
  logic dig_l, dig_r, dig_1;
  logic [4:0] code, code_r;
  logic [8*KM-1:0] head;
  logic [LW-1:0] pl, pr;
  logic [7:0] b, c;
  logic [7:0] tc;
  logic tc_nd, bad_l, bad_r, bad_1;
  logic is_print;
  logic read_pending;

  assign b = s_axis_tdata;
  assign is_print = b >= 8'h20 && b <= 8'h7E;
  assign s_axis_tready = state == ST_IDLE;

  // normalize the character read last cycle
  always_comb begin
    c = rd_data;
    if (c == 8'h09 || c == "-" || c == "_") c = " ";
    if (c >= "a" && c <= "z") c = c - 8'd32;
  end

  function automatic logic [7:0] nat(input logic [7:0] n [LINE_MAX],
                                     input logic [LW-1:0] len, input int i);
    return (i < int'(len) && i < int'(LINE_MAX)) ? n[i] : 8'd0;
  endfunction

  always_comb begin
    for (int i = 0; i < int'(KM); i++) head[8*i +: 8] = nat(norm, nlen, i);
    pl = (nlen >= LW'(4) && norm[0] == "L" && norm[1] == "E" && norm[2] == "F" &&
          norm[3] == "T") ? LW'(4) : LW'(1);
    pr = (nlen >= LW'(5) && norm[0] == "R" && norm[1] == "I" && norm[2] == "G" &&
          norm[3] == "H" && norm[4] == "T") ? LW'(5) : LW'(1);
  end

  // tail position check: an optional space right after the prefix, then digits to the end
  always_comb begin
    tc = norm[tp[AW-1:0]];
    tc_nd = tc < "0" || tc > "9";
    bad_l = (tp == '0 && nlen <= pl) || (tp >= pl && tc_nd && !(tc == " " && tp == pl));
    bad_r = (tp == '0 && nlen <= pr) || (tp >= pr && tc_nd && !(tc == " " && tp == pr));
    bad_1 = (tp == '0 && nlen <= LW'(1)) ||
            (tp >= LW'(1) && tc_nd && !(tc == " " && tp == LW'(1)));
  end

  utcr_matcher #(.NORM_W(LW)) u_match (
    .head(head), .norm_len(nlen),
    .all_digits_l(dig_l), .all_digits_r(dig_r), .all_digits_1(dig_1),
    .code(code)
  );

  always_ff @(posedge clk) begin
    if (read_pending) rd_data <= mem[rd_idx[AW-1:0]];
    if (s_axis_tvalid && s_axis_tready && is_print && !(line_length == '0 &&
        b >= "0" && b <= "3") && !(line_length == LW'(1) && first_nine &&
        b == "1") && line_length < LW'(LINE_MAX - 1))
      mem[line_length[AW-1:0]] <= b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      line_length <= '0;
      mapping <= 1'b0;
      debug <= 1'b0;
      overflows <= '0;
      errors <= '0;
      m_axis_tvalid <= 1'b0;
      read_pending <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (b == 8'h0D || b == 8'h0A) begin
              if (line_length != '0) begin
                src_n <= line_length;
                line_length <= '0;
                rd_idx <= '0;
                nlen <= '0;
                prev_space <= 1'b1;
                read_pending <= 1'b1;
                state <= ST_NORM;
              end
            end else if (is_print) begin
              if (line_length == '0 && b >= "0" && b <= "3") begin
                norm[0] <= b;
                nlen <= LW'(1);
                state <= ST_MATCH;
              end else if (line_length == LW'(1) && first_nine && b == "1") begin
                norm[0] <= "9";
                norm[1] <= "1";
                nlen <= LW'(2);
                line_length <= '0;
                state <= ST_MATCH;
              end else if (line_length < LW'(LINE_MAX - 1)) begin
                if (line_length == '0) first_nine <= b == "9";
                line_length <= line_length + LW'(1);
              end else begin
                line_length <= '0;
                if (overflows != 16'hFFFF) overflows <= overflows + 16'd1;
              end
            end
          end
        end
        ST_NORM: begin
          // one stored character per cycle through the normalizer
          if (rd_idx != '0) begin
            if (c == " ") begin
              if (!prev_space) begin
                norm[nlen[AW-1:0]] <= " ";
                nlen <= nlen + LW'(1);
              end
              prev_space <= 1'b1;
            end else begin
              norm[nlen[AW-1:0]] <= c;
              nlen <= nlen + LW'(1);
              prev_space <= 1'b0;
            end
          end
          if (rd_idx == src_n) begin
            read_pending <= 1'b0;
            state <= ST_TRIM;
          end else begin
            rd_idx <= rd_idx + LW'(1);
          end
        end
        ST_TRIM: begin
          if (nlen != '0 && norm[nlen[AW-1:0] - AW'(1)] == " ") nlen <= nlen - LW'(1);
          tp <= '0;
          dig_l <= 1'b1;
          dig_r <= 1'b1;
          dig_1 <= 1'b1;
          state <= ST_TAIL;
        end
        ST_TAIL: begin
          // digit check of the tail after a turn prefix, one position per cycle
          if (tp == nlen) begin
            state <= ST_MATCH;
          end else begin
            if (bad_l) dig_l <= 1'b0;
            if (bad_r) dig_r <= 1'b0;
            if (bad_1) dig_1 <= 1'b0;
            tp <= tp + LW'(1);
          end
        end
        ST_MATCH: begin
          code_r <= code;
          if (code == utcr_pkg::CMD_UNKNOWN) begin
            if (errors != 16'hFFFF) errors <= errors + 16'd1;
          end else if (code == utcr_pkg::CMD_START_MAPPING) mapping <= 1'b1;
          else if (code == utcr_pkg::CMD_STOP_ALL) mapping <= 1'b0;
          else if (code == utcr_pkg::CMD_DEBUG_ON) debug <= 1'b1;
          else if (code == utcr_pkg::CMD_DEBUG_OFF) debug <= 1'b0;
          m_axis_tvalid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, errors, overflows, debug, mapping, code_r};

  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> state == ST_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while result waits");
  assert property (@(posedge clk) disable iff (rst)
    line_length < LW'(LINE_MAX)) else $error("line length out of range");

endmodule
